[rtl/core/fcr_pkg.sv]
package fcr_pkg;

    // Frame format
    localparam logic [7:0] START_BYTE  = 8'h7E;
    localparam logic [7:0] END_BYTE    = 8'h7F;
    localparam int unsigned MAX_PAYLOAD = 50;
    localparam int unsigned HEAD_DEPTH  = 11;

    // Parser phases
    localparam logic [2:0] PH_START   = 3'd0;
    localparam logic [2:0] PH_LEN     = 3'd1;
    localparam logic [2:0] PH_TYPE    = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_END     = 3'd4;

    // Command types
    localparam logic [7:0] TY_FWD_ON   = 8'h17;
    localparam logic [7:0] TY_FWD_OFF  = 8'h16;
    localparam logic [7:0] TY_LOG_ON   = 8'h19;
    localparam logic [7:0] TY_LOG_OFF  = 8'h18;
    localparam logic [7:0] TY_SCAN_ON  = 8'h20;
    localparam logic [7:0] TY_SCAN_OFF = 8'h21;
    localparam logic [7:0] TY_DISCONN  = 8'h22;
    localparam logic [7:0] TY_PARAMS   = 8'h23;
    localparam logic [7:0] TY_SEND_A   = 8'h24;
    localparam logic [7:0] TY_SEND_B   = 8'h25;
    localparam logic [7:0] TY_SEND_1   = 8'h30;

    // Event codes
    localparam logic [3:0] EV_BAD_LEN    = 4'd0;
    localparam logic [3:0] EV_BAD_END    = 4'd1;
    localparam logic [3:0] EV_UNKNOWN    = 4'd2;
    localparam logic [3:0] EV_FWD_ON     = 4'd3;
    localparam logic [3:0] EV_FWD_OFF    = 4'd4;
    localparam logic [3:0] EV_LOG_ON     = 4'd5;
    localparam logic [3:0] EV_LOG_OFF    = 4'd6;
    localparam logic [3:0] EV_SCAN_ON    = 4'd7;
    localparam logic [3:0] EV_SCAN_OFF   = 4'd8;
    localparam logic [3:0] EV_PARAMS_OK  = 4'd9;
    localparam logic [3:0] EV_PARAMS_LEN = 4'd10;
    localparam logic [3:0] EV_DISCONNECT = 4'd11;
    localparam logic [3:0] EV_SEND       = 4'd12;
    localparam logic [3:0] EV_SEND_SHORT = 4'd13;

    // Command kinds passed from parser to executor
    localparam logic [1:0] K_BAD_LEN = 2'd0;
    localparam logic [1:0] K_BAD_END = 2'd1;
    localparam logic [1:0] K_EXEC    = 2'd2;

    typedef struct packed {
        logic [1:0]                      kind;
        logic [7:0]                      ftype;
        logic [5:0]                      flen;
        logic [HEAD_DEPTH-1:0][7:0]      head;
    } t_cmd;

    typedef struct packed {
        logic [3:0]  event_code;
        logic [7:0]  target_index;
        logic [2:0]  forward_count;
        logic [39:0] forward_data;
        logic [3:0]  mode_flags;
        logic [11:0] interval_units;
        logic [15:0] latency_units;
        logic [15:0] timeout_units;
        logic [7:0]  length_bytes;
        logic [14:0] radio_time_us;
    } t_result;

endpackage

[rtl/core/fcr_front.sv]
module fcr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_rx_byte,
    output logic          o_push,
    output fcr_pkg::t_cmd o_cmd
);

    logic [2:0]  r_phase, n_phase;
    logic [5:0]  r_len, n_len;
    logic [7:0]  r_type, n_type;
    logic [5:0]  r_pos, n_pos;
    logic [fcr_pkg::HEAD_DEPTH-1:0][7:0] r_head, n_head;

    // Parse one byte per transfer
    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_type  = r_type;
        n_pos   = r_pos;
        n_head  = r_head;
        o_push  = 1'b0;
        o_cmd.kind  = fcr_pkg::K_EXEC;
        o_cmd.ftype = r_type;
        o_cmd.flen  = r_len;
        o_cmd.head  = r_head;
        if (i_accept) begin
            case (r_phase)
                fcr_pkg::PH_LEN: begin
                    if (i_rx_byte > 8'(fcr_pkg::MAX_PAYLOAD)) begin
                        n_phase    = fcr_pkg::PH_START;
                        o_push     = 1'b1;
                        o_cmd.kind = fcr_pkg::K_BAD_LEN;
                    end else begin
                        n_len   = i_rx_byte[5:0];
                        n_phase = fcr_pkg::PH_TYPE;
                    end
                end
                fcr_pkg::PH_TYPE: begin
                    n_type  = i_rx_byte;
                    n_pos   = 6'd0;
                    n_phase = (r_len == 6'd0) ? fcr_pkg::PH_END : fcr_pkg::PH_PAYLOAD;
                end
                fcr_pkg::PH_PAYLOAD: begin
                    // keep only the head of the payload, count the rest
                    if (r_pos < 6'(fcr_pkg::HEAD_DEPTH)) begin
                        n_head[r_pos[3:0]] = i_rx_byte;
                    end
                    n_pos = r_pos + 6'd1;
                    if (n_pos == r_len) begin
                        n_phase = fcr_pkg::PH_END;
                    end
                end
                fcr_pkg::PH_END: begin
                    n_phase = fcr_pkg::PH_START;
                    o_push  = 1'b1;
                    o_cmd.kind = (i_rx_byte == fcr_pkg::END_BYTE) ?
                                 fcr_pkg::K_EXEC : fcr_pkg::K_BAD_END;
                end
                default: begin
                    n_phase = (i_rx_byte == fcr_pkg::START_BYTE) ?
                              fcr_pkg::PH_LEN : fcr_pkg::PH_START;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= fcr_pkg::PH_START;
            r_len   <= '0;
            r_type  <= '0;
            r_pos   <= '0;
            r_head  <= '0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_type  <= n_type;
            r_pos   <= n_pos;
            r_head  <= n_head;
        end
    end

endmodule

[rtl/core/fcr_queue.sv]
module fcr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fcr_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_pop,
    output fcr_pkg::t_cmd o_cmd
);

    fcr_pkg::t_cmd r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

[rtl/core/fcr_back.sv]
module fcr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  fcr_pkg::t_cmd    i_cmd,
    output logic             o_q_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output fcr_pkg::t_result o_res
);

    localparam logic ST_RUN     = 1'b0;
    localparam logic ST_TIMEOUT = 1'b1;

    logic        r_state, n_state;
    logic        r_fwd, n_fwd, r_log, n_log, r_scan, n_scan, r_phy, n_phy;
    logic [11:0] r_interval, n_interval;
    logic [15:0] r_latency, n_latency;
    logic [15:0] r_timeout, n_timeout;
    logic [7:0]  r_length, n_length;
    logic [14:0] r_radio, n_radio;
    logic [28:0] r_prod, n_prod;
    logic [15:0] r_req, n_req;
    logic        r_out_valid, n_out_valid;
    fcr_pkg::t_result r_res, n_res;

    logic        out_free, load;
    logic [3:0]  code;
    logic [7:0]  target;
    logic [2:0]  count;
    logic [39:0] data;
    logic [15:0] w_int, w_len, w_radio;
    logic [30:0] need_x5;
    logic [15:0] need;

    assign out_free = !r_out_valid || !i_out_stall;
    assign w_int    = {i_cmd.head[2], i_cmd.head[1]};
    assign w_len    = {i_cmd.head[8], i_cmd.head[7]};
    assign w_radio  = {i_cmd.head[10], i_cmd.head[9]};

    // ceil(product * 5 / 4), truncated to 16 bits
    assign need_x5 = {r_prod, 2'b00} + 31'(r_prod);
    assign need    = 16'((32'(need_x5) + 32'd3) >> 2);

    always_comb begin
        n_state    = r_state;
        n_fwd      = r_fwd;
        n_log      = r_log;
        n_scan     = r_scan;
        n_phy      = r_phy;
        n_interval = r_interval;
        n_latency  = r_latency;
        n_timeout  = r_timeout;
        n_length   = r_length;
        n_radio    = r_radio;
        n_prod     = r_prod;
        n_req      = r_req;
        o_q_pop    = 1'b0;
        load       = 1'b0;
        code       = fcr_pkg::EV_UNKNOWN;
        target     = 8'd0;
        count      = 3'd0;
        data       = 40'd0;

        if (r_state == ST_TIMEOUT) begin
            // finish the parameter update
            if (out_free) begin
                n_timeout = (r_req >= need) ? r_req : need;
                code      = fcr_pkg::EV_PARAMS_OK;
                load      = 1'b1;
                n_state   = ST_RUN;
            end
        end else if (i_q_valid && out_free) begin
            o_q_pop = 1'b1;
            load    = 1'b1;
            case (i_cmd.kind)
                fcr_pkg::K_BAD_LEN: code = fcr_pkg::EV_BAD_LEN;
                fcr_pkg::K_BAD_END: code = fcr_pkg::EV_BAD_END;
                default: begin
                    case (i_cmd.ftype)
                        fcr_pkg::TY_FWD_ON: begin
                            n_fwd = 1'b1;
                            code  = fcr_pkg::EV_FWD_ON;
                        end
                        fcr_pkg::TY_FWD_OFF: begin
                            n_fwd = 1'b0;
                            code  = fcr_pkg::EV_FWD_OFF;
                        end
                        fcr_pkg::TY_LOG_ON: begin
                            n_log = 1'b1;
                            code  = fcr_pkg::EV_LOG_ON;
                        end
                        fcr_pkg::TY_LOG_OFF: begin
                            n_log = 1'b0;
                            code  = fcr_pkg::EV_LOG_OFF;
                        end
                        fcr_pkg::TY_SCAN_ON: begin
                            n_scan = 1'b1;
                            code   = fcr_pkg::EV_SCAN_ON;
                        end
                        fcr_pkg::TY_SCAN_OFF: begin
                            n_scan = 1'b0;
                            code   = fcr_pkg::EV_SCAN_OFF;
                        end
                        fcr_pkg::TY_PARAMS: begin
                            if (i_cmd.flen != 6'(fcr_pkg::HEAD_DEPTH)) begin
                                code = fcr_pkg::EV_PARAMS_LEN;
                            end else begin
                                // take the checked fields, start the timeout product
                                load = 1'b0;
                                if (i_cmd.head[0] == 8'd1) n_phy = 1'b0;
                                if (i_cmd.head[0] == 8'd2) n_phy = 1'b1;
                                if (w_int >= 16'd6 && w_int <= 16'd3200) begin
                                    n_interval = w_int[11:0];
                                end
                                n_latency = {i_cmd.head[4], i_cmd.head[3]};
                                n_prod    = 29'(17'(n_latency) + 17'd1) * 29'(n_interval);
                                n_req     = {i_cmd.head[6], i_cmd.head[5]};
                                if (w_len >= 16'd27 && w_len <= 16'd251) begin
                                    n_length = w_len[7:0];
                                end
                                if (w_radio >= 16'd328 && w_radio <= 16'd17040) begin
                                    n_radio = w_radio[14:0];
                                end
                                n_state = ST_TIMEOUT;
                            end
                        end
                        fcr_pkg::TY_DISCONN: begin
                            code   = fcr_pkg::EV_DISCONNECT;
                            target = i_cmd.head[0];
                        end
                        fcr_pkg::TY_SEND_1: begin
                            if (i_cmd.flen < 6'd2) begin
                                code = fcr_pkg::EV_SEND_SHORT;
                            end else begin
                                code   = fcr_pkg::EV_SEND;
                                target = i_cmd.head[0];
                                count  = 3'd1;
                                data   = {32'd0, i_cmd.head[1]};
                            end
                        end
                        fcr_pkg::TY_SEND_A, fcr_pkg::TY_SEND_B: begin
                            if (i_cmd.flen < 6'd5) begin
                                code = fcr_pkg::EV_SEND_SHORT;
                            end else begin
                                code   = fcr_pkg::EV_SEND;
                                target = i_cmd.head[0];
                                count  = 3'd5;
                                data   = {i_cmd.head[4], i_cmd.head[3], i_cmd.head[2],
                                          i_cmd.head[1], i_cmd.ftype};
                            end
                        end
                        default: code = fcr_pkg::EV_UNKNOWN;
                    endcase
                end
            endcase
        end

        // Capture the result with the link state as it stands after the event
        n_out_valid = r_out_valid && i_out_stall;
        n_res       = r_res;
        if (load) begin
            n_out_valid          = 1'b1;
            n_res.event_code     = code;
            n_res.target_index   = target;
            n_res.forward_count  = count;
            n_res.forward_data   = data;
            n_res.mode_flags     = {n_phy, n_scan, n_log, n_fwd};
            n_res.interval_units = n_interval;
            n_res.latency_units  = n_latency;
            n_res.timeout_units  = n_timeout;
            n_res.length_bytes   = n_length;
            n_res.radio_time_us  = n_radio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_fwd       <= 1'b0;
            r_log       <= 1'b1;
            r_scan      <= 1'b1;
            r_phy       <= 1'b0;
            r_interval  <= 12'd10;
            r_latency   <= 16'd0;
            r_timeout   <= 16'd1000;
            r_length    <= 8'd73;
            r_radio     <= 15'd800;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fwd       <= n_fwd;
            r_log       <= n_log;
            r_scan      <= n_scan;
            r_phy       <= n_phy;
            r_interval  <= n_interval;
            r_latency   <= n_latency;
            r_timeout   <= n_timeout;
            r_length    <= n_length;
            r_radio     <= n_radio;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_req  <= n_req;
        r_res  <= n_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

endmodule

[rtl/core/framed_command_receiver_top.sv]
// Framed command receiver.
// Input channel (i_in_valid / o_in_stall / i_rx_byte) takes one received byte per
// transfer and parses frames: 0x7E, length, type, payload, 0x7F. Output channel
// (o_out_valid / i_out_stall / payload ports) gives at most one event per byte:
// errors, flag changes, link parameter updates, disconnect and send requests,
// together with the mode flags and link parameters as they stand after the event.
// The input takes one byte per cycle while o_in_stall is low. The parser front
// end pushes finished frames into a two-entry queue; the executor drains one
// entry per cycle while the output is free, and passes a link parameter update
// through an extra timeout state. From the byte that causes it, an event passes
// through a queue entry and the result register; a link parameter update also
// passes the registered timeout product before the compare.
// A stalled output holds its event; the executor then stops, the queue fills, and
// o_in_stall rises once both entries are taken. Reset (synchronous, active low)
// returns the parser to waiting for a start byte, empties the queue and output,
// and loads the default flags and link parameters.
module framed_command_receiver_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_event_code,
    output logic [7:0]  o_target_index,
    output logic [2:0]  o_forward_count,
    output logic [39:0] o_forward_data,
    output logic [3:0]  o_mode_flags,
    output logic [11:0] o_interval_units,
    output logic [15:0] o_latency_units,
    output logic [15:0] o_timeout_units,
    output logic [7:0]  o_length_bytes,
    output logic [14:0] o_radio_time_us
);

    logic             q_full, q_valid, q_pop, push, accept;
    fcr_pkg::t_cmd    push_cmd, q_cmd;
    fcr_pkg::t_result res;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    fcr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    fcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd)
    );

    fcr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (q_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (res)
    );

    assign o_event_code     = res.event_code;
    assign o_target_index   = res.target_index;
    assign o_forward_count  = res.forward_count;
    assign o_forward_data   = res.forward_data;
    assign o_mode_flags     = res.mode_flags;
    assign o_interval_units = res.interval_units;
    assign o_latency_units  = res.latency_units;
    assign o_timeout_units  = res.timeout_units;
    assign o_length_bytes   = res.length_bytes;
    assign o_radio_time_us  = res.radio_time_us;

endmodule
